### sv/open_addressing_hash_table_assert.svh
// Assertion helpers shared by the hash table RTL.
`ifndef OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH
`define OPEN_ADDRESSING_HASH_TABLE_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define OAHT_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define OAHT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/oaht_pkg.sv
package oaht_pkg;

   // Field widths of the request and response items.
   localparam int KIND_W  = 2;
   localparam int KEY_W   = 32;
   localparam int HASH_W  = 32;
   localparam int VALUE_W = 64;
   localparam int LIMIT_W = 9;

   // Reset value of the load limit register.
   localparam logic [LIMIT_W-1:0] LOAD_LIMIT_RESET = 9'd192;

   // Request kinds.
   localparam logic [KIND_W-1:0] KIND_GET = 2'd0;
   localparam logic [KIND_W-1:0] KIND_SET = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DEL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

   // Slot tags.
   localparam logic [1:0] TAG_EMPTY = 2'd0;
   localparam logic [1:0] TAG_FULL  = 2'd1;
   localparam logic [1:0] TAG_TOMB  = 2'd2;

   // One slot of the table as it is stored in memory.
   typedef struct packed {
      logic [1:0]         tag;
      logic [KEY_W-1:0]   key;
      logic [VALUE_W-1:0] value;
   } entry_type;

endpackage

### sv/oaht_slots.sv
module oaht_slots #(
   parameter int SLOTS = 256,
   parameter int AW    = 8
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  oaht_pkg::entry_type wr_data,
   input  logic [AW-1:0]       rd_addr,
   output oaht_pkg::entry_type rd_data
);

   oaht_pkg::entry_type mem [SLOTS];
   oaht_pkg::entry_type rd_data_ff;

   // Single write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Single read port with registered data.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/oaht_hmod.sv
module oaht_hmod #(
   parameter int SLOTS = 256,
   parameter int AW    = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [oaht_pkg::HASH_W-1:0] hash,
   output logic                        done,
   output logic [AW-1:0]               idx
);

   localparam int            HW      = oaht_pkg::HASH_W;
   localparam bit            POW2    = (SLOTS & (SLOTS - 1)) == 0;
   localparam logic [AW:0]   SLOTS_X = (AW + 1)'(SLOTS);
   // Reciprocal of the slot count scaled by 2^32, rounded down.
   localparam logic [HW-1:0] RECIP   = HW'((64'd1 << HW) / SLOTS);

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_MUL   = 2'd1;
   localparam logic [1:0] PH_SCALE = 2'd2;
   localparam logic [1:0] PH_SUB   = 2'd3;

   logic [1:0]      phase_ff, phase_in;
   logic            done_ff, done_in;
   logic [AW-1:0]   r_ff, r_in;
   logic [HW-1:0]   h_ff, h_in;
   logic [AW:0]     q_ff, q_in;
   logic [AW:0]     qd_ff, qd_in;
   logic [2*HW-1:0] prod;
   logic [AW:0]     rem;

   // Reduce the hash modulo the slot count: a plain mask for a power of two,
   // otherwise a reciprocal multiply gives a quotient that is low by at most
   // one, so the remainder fits in AW+1 bits and needs one compare and
   // subtract. Only the low AW+1 bits of the quotient are carried.
   always_comb begin
      phase_in = phase_ff;
      done_in  = 1'b0;
      r_in     = r_ff;
      h_in     = h_ff;
      q_in     = q_ff;
      qd_in    = qd_ff;
      prod     = (2*HW)'(h_ff) * (2*HW)'(RECIP);
      rem      = h_ff[AW:0] - qd_ff;
      if (rem >= SLOTS_X) begin
         rem = rem - SLOTS_X;
      end
      if (start) begin
         if (POW2) begin
            r_in    = hash[AW-1:0];
            done_in = 1'b1;
         end else begin
            h_in     = hash;
            phase_in = PH_MUL;
         end
      end else begin
         case (phase_ff)
            PH_MUL: begin
               q_in     = prod[HW +: AW + 1];
               phase_in = PH_SCALE;
            end
            PH_SCALE: begin
               qd_in    = q_ff * SLOTS_X;
               phase_in = PH_SUB;
            end
            PH_SUB: begin
               r_in     = rem[AW-1:0];
               done_in  = 1'b1;
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff  <= r_in;
      h_ff  <= h_in;
      q_ff  <= q_in;
      qd_ff <= qd_in;
   end

   assign done = done_ff;
   assign idx  = r_ff;

endmodule

### sv/open_addressing_hash_table.sv
// Open-addressing key/value table with linear probing and tombstones.
// Requests enter on the req_ channel (kind, key_id, key_hash, value_in) and
// each one produces exactly one item on the rsp_ channel (answer, value_out,
// refused). Both channels move an item on a rising edge where valid is high
// and stall is low. The user must write the load limit register through
// csr_wr_en and csr_wr_data only while the table is idle; the block itself
// does not enforce this. One request is handled at a time; req_stall is
// high until it finishes. A request's result goes to the output register
// after a probe of 1 to SLOTS slots, and the block is idle again once the
// result is registered. The probe loop reads one slot per cycle from the
// slot memory. When SLOTS is not a power of two, the starting slot comes
// from a reciprocal multiply, a scaling multiply and a compare and
// subtract. A NOP request skips the probe.
// After reset a clearing pass marks every slot empty, one slot per cycle,
// and no request is taken until it ends; the load limit resets to 192.
// A stalled response holds in the output register, and the next request
// finishes its probe but waits for the register to drain before completing.
module open_addressing_hash_table #(
   parameter int SLOTS = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [oaht_pkg::KIND_W-1:0]  req_kind,
   input  logic [oaht_pkg::KEY_W-1:0]   req_key_id,
   input  logic [oaht_pkg::HASH_W-1:0]  req_key_hash,
   input  logic [oaht_pkg::VALUE_W-1:0] req_value_in,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_answer,
   output logic [oaht_pkg::VALUE_W-1:0] rsp_value_out,
   output logic                         rsp_refused,
   input  logic                         csr_wr_en,
   input  logic [oaht_pkg::LIMIT_W-1:0] csr_wr_data
);

`include "open_addressing_hash_table_assert.svh"

   localparam int AW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);
   localparam int LW = oaht_pkg::LIMIT_W;

   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_HASH  = 3'd2;
   localparam logic [2:0] ST_PROBE = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   localparam logic [AW-1:0] LAST_IDX = AW'(SLOTS - 1);
   localparam logic [CW-1:0] LAST_CNT = CW'(SLOTS - 1);

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] tomb_ff, tomb_in;
   logic          seen_ff, seen_in;
   logic [CW-1:0] n_ff, n_in;
   logic [LW-1:0] used_ff, used_in;
   logic [LW-1:0] limit_ff, limit_in;

   logic [oaht_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic [oaht_pkg::KEY_W-1:0]   key_ff, key_in;
   logic [oaht_pkg::VALUE_W-1:0] value_ff, value_in;

   logic                         res_ans_ff, res_ans_in;
   logic [oaht_pkg::VALUE_W-1:0] res_val_ff, res_val_in;
   logic                         res_ref_ff, res_ref_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_ans_ff, rsp_ans_in;
   logic [oaht_pkg::VALUE_W-1:0] rsp_val_ff, rsp_val_in;
   logic                         rsp_ref_ff, rsp_ref_in;

   logic                accept;
   logic                mod_start;
   logic                mod_done;
   logic [AW-1:0]       mod_idx;
   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   oaht_pkg::entry_type wr_data;
   oaht_pkg::entry_type rd_data;

   logic          cur_empty, cur_tomb, cur_match, stop, have_free, over;
   logic          where_empty;
   logic [AW-1:0] where_idx;
   logic [AW-1:0] next_idx;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign mod_start = accept && (req_kind != oaht_pkg::KIND_NOP);

   oaht_hmod #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_hmod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .hash  (req_key_hash),
      .done  (mod_done),
      .idx   (mod_idx)
   );

   // The read address follows the next probe index, so rd_data holds the slot
   // for idx_ff in the same cycle that idx_ff holds its index.
   oaht_slots #(
      .SLOTS (SLOTS),
      .AW    (AW)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   // Classify the slot under the probe.
   always_comb begin
      cur_empty   = (rd_data.tag == oaht_pkg::TAG_EMPTY);
      cur_tomb    = (rd_data.tag == oaht_pkg::TAG_TOMB);
      cur_match   = (rd_data.tag == oaht_pkg::TAG_FULL) && (rd_data.key == key_ff);
      stop        = cur_empty || cur_match || (n_ff == LAST_CNT);
      have_free   = cur_empty || seen_ff || cur_tomb;
      where_idx   = seen_ff ? tomb_ff : idx_ff;
      where_empty = !seen_ff && cur_empty;
      next_idx    = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
      over        = ({1'b0, used_ff} + (LW + 1)'(1)) > {1'b0, limit_ff};
   end

   // Sequencer: clear, take a request, find the start slot, probe, respond.
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      idx_in       = idx_ff;
      tomb_in      = tomb_ff;
      seen_in      = seen_ff;
      n_in         = n_ff;
      used_in      = used_ff;
      limit_in     = csr_wr_en ? csr_wr_data : limit_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      res_ans_in   = res_ans_ff;
      res_val_in   = res_val_ff;
      res_ref_in   = res_ref_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ans_in   = rsp_ans_ff;
      rsp_val_in   = rsp_val_ff;
      rsp_ref_in   = rsp_ref_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en       = 1'b1;
            wr_addr     = clr_ff;
            wr_data.tag = oaht_pkg::TAG_EMPTY;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_kind;
               key_in     = req_key_id;
               value_in   = req_value_in;
               seen_in    = 1'b0;
               n_in       = '0;
               res_ans_in = 1'b0;
               res_val_in = '0;
               res_ref_in = 1'b0;
               state_in   = (req_kind == oaht_pkg::KIND_NOP) ? ST_DONE : ST_HASH;
            end
         end

         ST_HASH: begin
            if (mod_done) begin
               idx_in   = mod_idx;
               state_in = ST_PROBE;
            end
         end

         ST_PROBE: begin
            if (!stop) begin
               idx_in = next_idx;
               n_in   = n_ff + 1'b1;
               if (cur_tomb && !seen_ff) begin
                  seen_in = 1'b1;
                  tomb_in = idx_ff;
               end
            end else begin
               state_in = ST_DONE;
               case (kind_ff)
                  oaht_pkg::KIND_GET: begin
                     if (cur_match) begin
                        res_ans_in = 1'b1;
                        res_val_in = rd_data.value;
                     end
                  end
                  oaht_pkg::KIND_SET: begin
                     if (cur_match) begin
                        wr_en         = 1'b1;
                        wr_addr       = idx_ff;
                        wr_data.tag   = oaht_pkg::TAG_FULL;
                        wr_data.key   = rd_data.key;
                        wr_data.value = value_ff;
                     end else if (over || !have_free) begin
                        res_ref_in = 1'b1;
                     end else begin
                        wr_en         = 1'b1;
                        wr_addr       = where_idx;
                        wr_data.tag   = oaht_pkg::TAG_FULL;
                        wr_data.key   = key_ff;
                        wr_data.value = value_ff;
                        res_ans_in    = 1'b1;
                        if (where_empty) begin
                           used_in = used_ff + 1'b1;
                        end
                     end
                  end
                  oaht_pkg::KIND_DEL: begin
                     if (cur_match) begin
                        wr_en         = 1'b1;
                        wr_addr       = idx_ff;
                        wr_data.tag   = oaht_pkg::TAG_TOMB;
                        wr_data.key   = rd_data.key;
                        wr_data.value = rd_data.value;
                        res_ans_in    = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_ans_in   = res_ans_ff;
               rsp_val_in   = res_val_ff;
               rsp_ref_in   = res_ref_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         seen_ff      <= 1'b0;
         n_ff         <= '0;
         used_ff      <= '0;
         limit_ff     <= oaht_pkg::LOAD_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         seen_ff      <= seen_in;
         n_ff         <= n_in;
         used_ff      <= used_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      tomb_ff    <= tomb_in;
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
      res_ans_ff <= res_ans_in;
      res_val_ff <= res_val_in;
      res_ref_ff <= res_ref_in;
      rsp_ans_ff <= rsp_ans_in;
      rsp_val_ff <= rsp_val_in;
      rsp_ref_ff <= rsp_ref_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_answer    = rsp_ans_ff;
   assign rsp_value_out = rsp_val_ff;
   assign rsp_refused   = rsp_ref_ff;

   // Checks on the sequencer.
   `OAHT_ASSERT_NOW(a_write_phase, clock, reset, wr_en,
      (state_ff == ST_PROBE) || (state_ff == ST_CLEAR), "slot write outside probe or clear")
   `OAHT_ASSERT_NOW(a_probe_bound, clock, reset, state_ff == ST_PROBE,
      n_ff <= LAST_CNT, "probe ran past the slot count")
   `OAHT_ASSERT_NEXT(a_used_monotone, clock, reset, 1'b1,
      used_ff >= $past(used_ff), "used count decreased")
   `OAHT_ASSERT_NEXT(a_accept_next, clock, reset, accept,
      (state_ff == ST_HASH) || (state_ff == ST_DONE), "accepted item not taken up")

endmodule
